[rtl/clpb_pkg.sv]
// Package for the cell list position binner: sizes, request and response
// types, memory entry layout, unit command structs and state encodings.
// Depends on nothing; every RTL file refers to it by scoped names.
package clpb_pkg;

    // Storage sizes.
    localparam int MAX_AGENTS = 1024;
    localparam int MAX_CELLS  = 4096;

    localparam int AGENT_W    = $clog2(MAX_AGENTS);
    localparam int LINK_W     = AGENT_W + 1;
    localparam int CELL_IDX_W = $clog2(MAX_CELLS);
    localparam int CELL_W     = CELL_IDX_W + 1;

    // Null markers: an empty link and "not in any cell".
    localparam logic [LINK_W-1:0] NIL_AGENT = LINK_W'(MAX_AGENTS);
    localparam logic [CELL_W-1:0] NO_CELL   = CELL_W'(MAX_CELLS);

    // Field and datapath widths.
    localparam int POS_W      = 32;
    localparam int FOLD_W     = 31;
    localparam int COUNT_W    = 13;
    localparam int OUT_IDX_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W      = FOLD_W + COUNT_W;
    localparam int DVS_W      = LEN_W + 1;
    localparam int SH_W       = POS_W;
    localparam int STEP_W     = $clog2(SH_W + 1);
    localparam int T_W        = 2 * COUNT_W + 1;
    localparam int IDX_W      = 3 * COUNT_W + 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_MODE  = 3'd0,
        CFG_CELL_WIDTH = 3'd1,
        CFG_CELLS_X    = 3'd2,
        CFG_CELLS_Y    = 3'd3,
        CFG_CELLS_Z    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [AGENT_W-1:0]      agent_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic [FOLD_W-1:0]    folded_x;
        logic [FOLD_W-1:0]    folded_y;
        logic [FOLD_W-1:0]    folded_z;
        logic [OUT_IDX_W-1:0] cell_index;
        logic                 moved;
    } rsp_t;

    // One word of the agent memory.
    typedef struct packed {
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
        logic [CELL_W-1:0] cell_idx;
    } agent_entry_t;

    typedef struct packed {
        logic              start;
        logic [DVS_W-1:0]  init_rem;
        logic [SH_W-1:0]   shift_in;
        logic [STEP_W-1:0] steps;
        logic [DVS_W-1:0]  divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DVS_W-1:0] rem;
        logic [SH_W-1:0]  quo;
    } div_res_t;

    typedef struct packed {
        logic               start;
        logic [AGENT_W-1:0] agent;
        logic [CELL_W-1:0]  cell_idx;
    } list_cmd_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic moved;
    } list_sts_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LEN,
        B_FOLD,
        B_FOLD_WAIT,
        B_QUOT,
        B_QUOT_WAIT,
        B_IDX_A,
        B_IDX_B,
        B_LIST,
        B_LIST_WAIT,
        B_DONE
    } bin_state_t;

    typedef enum logic [3:0] {
        L_CLEAR,
        L_IDLE,
        L_CHK,
        L_P_WR,
        L_HEAD_UNL,
        L_N_RD,
        L_N_WR,
        L_LINK,
        L_H_CHK,
        L_F_WR,
        L_SELF_WR,
        L_HEAD_WR,
        L_DONE
    } list_state_t;

endpackage

[rtl/clpb_divider.sv]
// Restoring divider that retires one quotient bit per cycle.
// Depends on clpb_pkg for widths and the command and result structs.
module clpb_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  clpb_pkg::div_cmd_t  cmd,
    output clpb_pkg::div_res_t  res
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [clpb_pkg::STEP_W-1:0]   cnt_reg;
    logic [clpb_pkg::DVS_W-1:0]    rem_reg;
    logic [clpb_pkg::DVS_W-1:0]    dvs_reg;
    logic [clpb_pkg::SH_W-1:0]     sh_reg;
    logic [clpb_pkg::SH_W-1:0]     quo_reg;
    logic [clpb_pkg::DVS_W:0]      trial;
    logic                          fits;
    logic [clpb_pkg::DVS_W-1:0]    rem_step;

    // Shift in the next dividend bit and subtract where the divisor fits.
    assign trial    = {rem_reg, sh_reg[clpb_pkg::SH_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_step = fits ? clpb_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                           : trial[clpb_pkg::DVS_W-1:0];

    // Step counter and completion strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == clpb_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= cmd.init_rem;
            dvs_reg <= cmd.divisor;
            sh_reg  <= cmd.shift_in;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            sh_reg  <= {sh_reg[clpb_pkg::SH_W-2:0], 1'b0};
            quo_reg <= {quo_reg[clpb_pkg::SH_W-2:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;
    assign res.quo  = quo_reg;

endmodule

[rtl/clpb_list.sv]
// Cell list store: head memory and agent link memory with the sequencer
// that unlinks and relinks one agent. Depends on clpb_pkg.
module clpb_list (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clpb_pkg::list_cmd_t  cmd,
    output clpb_pkg::list_sts_t  sts
);

    logic [clpb_pkg::LINK_W-1:0]     head_mem [clpb_pkg::MAX_CELLS];
    clpb_pkg::agent_entry_t          agent_mem [clpb_pkg::MAX_AGENTS];

    clpb_pkg::list_state_t           state_reg, state_next;
    logic [clpb_pkg::CELL_IDX_W-1:0] clr_reg;
    logic [clpb_pkg::AGENT_W-1:0]    id_reg, id_next;
    logic [clpb_pkg::CELL_W-1:0]     newc_reg, newc_next;
    logic [clpb_pkg::CELL_W-1:0]     old_reg, old_next;
    logic [clpb_pkg::LINK_W-1:0]     p_reg, p_next;
    logic [clpb_pkg::LINK_W-1:0]     n_reg, n_next;
    logic [clpb_pkg::LINK_W-1:0]     f_reg, f_next;
    logic                            moved_reg, moved_next;

    logic [clpb_pkg::LINK_W-1:0]     h_rdata_reg;
    clpb_pkg::agent_entry_t          a_rdata_reg;
    logic                            h_re, h_we, a_re, a_we;
    logic [clpb_pkg::CELL_IDX_W-1:0] h_addr;
    logic [clpb_pkg::AGENT_W-1:0]    a_addr;
    logic [clpb_pkg::LINK_W-1:0]     h_wdata;
    clpb_pkg::agent_entry_t          a_wdata;
    logic                            newc_ok;
    logic                            done_flag;

    assign newc_ok = newc_reg != clpb_pkg::NO_CELL;

    // Single-port memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            head_mem[h_addr] <= h_wdata;
        end
        if (h_re)
        begin
            h_rdata_reg <= head_mem[h_addr];
        end
        if (a_we)
        begin
            agent_mem[a_addr] <= a_wdata;
        end
        if (a_re)
        begin
            a_rdata_reg <= agent_mem[a_addr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clpb_pkg::L_CLEAR;
            clr_reg   <= '0;
            moved_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            moved_reg <= moved_next;
            if (state_reg == clpb_pkg::L_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // Per-request working registers.
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        newc_reg <= newc_next;
        old_reg  <= old_next;
        p_reg    <= p_next;
        n_reg    <= n_next;
        f_reg    <= f_next;
    end

    // Sequencer: one memory access per port and cycle.
    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        newc_next  = newc_reg;
        old_next   = old_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        f_next     = f_reg;
        moved_next = moved_reg;
        h_re       = 1'b0;
        h_we       = 1'b0;
        a_re       = 1'b0;
        a_we       = 1'b0;
        h_addr     = '0;
        a_addr     = '0;
        h_wdata    = '0;
        a_wdata    = '0;
        done_flag  = 1'b0;
        unique case (state_reg)
            clpb_pkg::L_CLEAR:
            begin
                // Clearing pass: every head empty, every agent in no cell.
                h_we    = 1'b1;
                h_addr  = clr_reg;
                h_wdata = clpb_pkg::NIL_AGENT;
                if (clr_reg[clpb_pkg::CELL_IDX_W-1:clpb_pkg::AGENT_W] == '0)
                begin
                    a_we    = 1'b1;
                    a_addr  = clr_reg[clpb_pkg::AGENT_W-1:0];
                    a_wdata = '{prev: clpb_pkg::NIL_AGENT, next: clpb_pkg::NIL_AGENT,
                                cell_idx: clpb_pkg::NO_CELL};
                end
                if (clr_reg == '1)
                begin
                    state_next = clpb_pkg::L_IDLE;
                end
            end
            clpb_pkg::L_IDLE:
            begin
                if (cmd.start)
                begin
                    id_next    = cmd.agent;
                    newc_next  = cmd.cell_idx;
                    a_re       = 1'b1;
                    a_addr     = cmd.agent;
                    state_next = clpb_pkg::L_CHK;
                end
            end
            clpb_pkg::L_CHK:
            begin
                p_next     = a_rdata_reg.prev;
                n_next     = a_rdata_reg.next;
                old_next   = a_rdata_reg.cell_idx;
                moved_next = a_rdata_reg.cell_idx != newc_reg;
                if (a_rdata_reg.cell_idx == newc_reg)
                begin
                    state_next = clpb_pkg::L_DONE;
                end
                else if (a_rdata_reg.cell_idx != clpb_pkg::NO_CELL)
                begin
                    if (a_rdata_reg.prev != clpb_pkg::NIL_AGENT)
                    begin
                        a_re       = 1'b1;
                        a_addr     = a_rdata_reg.prev[clpb_pkg::AGENT_W-1:0];
                        state_next = clpb_pkg::L_P_WR;
                    end
                    else
                    begin
                        state_next = clpb_pkg::L_HEAD_UNL;
                    end
                end
                else
                begin
                    state_next = clpb_pkg::L_LINK;
                end
            end
            clpb_pkg::L_P_WR:
            begin
                // Predecessor skips over the leaving agent.
                a_we         = 1'b1;
                a_addr       = p_reg[clpb_pkg::AGENT_W-1:0];
                a_wdata      = a_rdata_reg;
                a_wdata.next = n_reg;
                state_next   = (n_reg != clpb_pkg::NIL_AGENT) ? clpb_pkg::L_N_RD
                                                               : clpb_pkg::L_LINK;
            end
            clpb_pkg::L_HEAD_UNL:
            begin
                // The leaving agent was the head of its old cell.
                h_we    = 1'b1;
                h_addr  = old_reg[clpb_pkg::CELL_IDX_W-1:0];
                h_wdata = n_reg;
                if (n_reg != clpb_pkg::NIL_AGENT)
                begin
                    a_re       = 1'b1;
                    a_addr     = n_reg[clpb_pkg::AGENT_W-1:0];
                    state_next = clpb_pkg::L_N_WR;
                end
                else
                begin
                    state_next = clpb_pkg::L_LINK;
                end
            end
            clpb_pkg::L_N_RD:
            begin
                a_re       = 1'b1;
                a_addr     = n_reg[clpb_pkg::AGENT_W-1:0];
                state_next = clpb_pkg::L_N_WR;
            end
            clpb_pkg::L_N_WR:
            begin
                // Successor points back past the leaving agent.
                a_we         = 1'b1;
                a_addr       = n_reg[clpb_pkg::AGENT_W-1:0];
                a_wdata      = a_rdata_reg;
                a_wdata.prev = p_reg;
                state_next   = clpb_pkg::L_LINK;
            end
            clpb_pkg::L_LINK:
            begin
                if (newc_ok)
                begin
                    h_re       = 1'b1;
                    h_addr     = newc_reg[clpb_pkg::CELL_IDX_W-1:0];
                    state_next = clpb_pkg::L_H_CHK;
                end
                else
                begin
                    state_next = clpb_pkg::L_SELF_WR;
                end
            end
            clpb_pkg::L_H_CHK:
            begin
                f_next = h_rdata_reg;
                if (h_rdata_reg != clpb_pkg::NIL_AGENT)
                begin
                    a_re       = 1'b1;
                    a_addr     = h_rdata_reg[clpb_pkg::AGENT_W-1:0];
                    state_next = clpb_pkg::L_F_WR;
                end
                else
                begin
                    state_next = clpb_pkg::L_SELF_WR;
                end
            end
            clpb_pkg::L_F_WR:
            begin
                // Old head of the new cell gets the agent as predecessor.
                a_we         = 1'b1;
                a_addr       = f_reg[clpb_pkg::AGENT_W-1:0];
                a_wdata      = a_rdata_reg;
                a_wdata.prev = {1'b0, id_reg};
                state_next   = clpb_pkg::L_SELF_WR;
            end
            clpb_pkg::L_SELF_WR:
            begin
                a_we   = 1'b1;
                a_addr = id_reg;
                if (newc_ok)
                begin
                    a_wdata    = '{prev: clpb_pkg::NIL_AGENT, next: f_reg, cell_idx: newc_reg};
                    state_next = clpb_pkg::L_HEAD_WR;
                end
                else
                begin
                    a_wdata    = '{prev: p_reg, next: n_reg, cell_idx: clpb_pkg::NO_CELL};
                    state_next = clpb_pkg::L_DONE;
                end
            end
            clpb_pkg::L_HEAD_WR:
            begin
                h_we       = 1'b1;
                h_addr     = newc_reg[clpb_pkg::CELL_IDX_W-1:0];
                h_wdata    = {1'b0, id_reg};
                state_next = clpb_pkg::L_DONE;
            end
            clpb_pkg::L_DONE:
            begin
                done_flag  = 1'b1;
                state_next = clpb_pkg::L_IDLE;
            end
            default:
            begin
                state_next = clpb_pkg::L_IDLE;
            end
        endcase
    end

    assign sts.ready = state_reg == clpb_pkg::L_IDLE;
    assign sts.done  = done_flag;
    assign sts.moved = moved_reg;

endmodule

[rtl/cell_list_position_binner_unit.sv]
// Each accepted request folds every axis in the shared serial divider with a
// 32-step fold remainder and then a 13-step cell quotient, then forms the cell
// index and updates the list memories before its response is issued.
// One request is in work at a time; a held-off response stalls the next.
// Reset: registers take their defaults at once, then a clearing pass over every
// cell empties the cell heads and agent cells; no request is taken until then.
module cell_list_position_binner_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  clpb_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output clpb_pkg::rsp_t                    rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [clpb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clpb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int FW = clpb_pkg::FOLD_W;
    localparam int CW = clpb_pkg::COUNT_W;
    localparam int LW = clpb_pkg::LEN_W;
    localparam int DW = clpb_pkg::DVS_W;

    logic          wrap_mode_reg;
    logic [FW-1:0] cell_width_reg;
    logic [CW-1:0] cells_x_reg, cells_y_reg, cells_z_reg;

    clpb_pkg::bin_state_t             state_reg, state_next;
    logic [1:0]                       axis_reg, axis_next;
    clpb_pkg::req_t                   req_reg, req_next;
    logic [LW-1:0]                    len_reg, len_next;
    logic [LW-1:0]                    f_reg, f_next;
    logic [2:0][FW-1:0]               fold_reg, fold_next;
    logic [2:0][CW-1:0]               gc_reg, gc_next;
    logic [clpb_pkg::T_W-1:0]         t_reg, t_next;
    logic [clpb_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic                             moved_reg, moved_next;
    clpb_pkg::rsp_t                   rsp_reg, rsp_next;
    logic                             rsp_valid_reg, rsp_valid_next;

    clpb_pkg::div_cmd_t               div_cmd;
    clpb_pkg::div_res_t               div_res;
    clpb_pkg::list_cmd_t              list_cmd;
    clpb_pkg::list_sts_t              list_sts;

    logic [FW-1:0]                    w_eff;
    logic [CW-1:0]                    cnt_sel, cnt_eff, cnt_max, cx_eff, cy_eff;
    logic signed [clpb_pkg::POS_W-1:0] pos_sel;
    logic                             pos_neg;
    logic [clpb_pkg::POS_W-1:0]       pos_abs;
    logic [DW-1:0]                    len_ext, two_len, r_abs, fold_val;
    logic [LW-1:0]                    len_prod;
    logic [CW-1:0]                    quo;
    logic                             in_grid;
    logic [FW-1:0]                    f_sat;

    // Configuration registers, always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mode_reg  <= 1'b0;
            cell_width_reg <= FW'(65536);
            cells_x_reg    <= CW'(16);
            cells_y_reg    <= CW'(16);
            cells_z_reg    <= CW'(16);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                clpb_pkg::CFG_WRAP_MODE:  wrap_mode_reg  <= cfg_data[0];
                clpb_pkg::CFG_CELL_WIDTH: cell_width_reg <= cfg_data[FW-1:0];
                clpb_pkg::CFG_CELLS_X:    cells_x_reg    <= cfg_data[CW-1:0];
                clpb_pkg::CFG_CELLS_Y:    cells_y_reg    <= cfg_data[CW-1:0];
                clpb_pkg::CFG_CELLS_Z:    cells_z_reg    <= cfg_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Zero sizes behave as one.
    assign w_eff  = (cell_width_reg == '0) ? FW'(1) : cell_width_reg;
    assign cx_eff = (cells_x_reg == '0) ? CW'(1) : cells_x_reg;
    assign cy_eff = (cells_y_reg == '0) ? CW'(1) : cells_y_reg;

    // Current axis operands.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                cnt_sel = cells_x_reg;
                pos_sel = req_reg.pos_x;
            end
            2'd1:
            begin
                cnt_sel = cells_y_reg;
                pos_sel = req_reg.pos_y;
            end
            default:
            begin
                cnt_sel = cells_z_reg;
                pos_sel = req_reg.pos_z;
            end
        endcase
    end

    assign cnt_eff  = (cnt_sel == '0) ? CW'(1) : cnt_sel;
    assign cnt_max  = cnt_eff - 1'b1;
    assign pos_neg  = pos_sel[clpb_pkg::POS_W-1];
    assign pos_abs  = pos_neg ? (~pos_sel + 1'b1) : pos_sel;
    assign len_prod = cnt_eff * w_eff;

    // Fold from the truncating remainder magnitude.
    assign len_ext = {1'b0, len_reg};
    assign two_len = {len_reg, 1'b0};
    assign r_abs   = div_res.rem;

    always_comb
    begin
        if (wrap_mode_reg)
        begin
            fold_val = (pos_neg && r_abs != '0) ? len_ext - r_abs : r_abs;
        end
        else
        begin
            fold_val = (r_abs < len_ext) ? r_abs : two_len - r_abs;
        end
    end

    assign quo     = div_res.quo[CW-1:0];
    assign f_sat   = (f_reg[LW-1:FW] != '0) ? '1 : f_reg[FW-1:0];
    assign in_grid = idx_reg[clpb_pkg::IDX_W-1:clpb_pkg::CELL_IDX_W] == '0;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clpb_pkg::B_IDLE;
            axis_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        len_reg   <= len_next;
        f_reg     <= f_next;
        fold_reg  <= fold_next;
        gc_reg    <= gc_next;
        t_reg     <= t_next;
        idx_reg   <= idx_next;
        moved_reg <= moved_next;
        rsp_reg   <= rsp_next;
    end

    // Request sequencer.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        req_next       = req_reg;
        len_next       = len_reg;
        f_next         = f_reg;
        fold_next      = fold_reg;
        gc_next        = gc_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        moved_next     = moved_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        div_cmd        = '0;
        list_cmd       = '0;
        unique case (state_reg)
            clpb_pkg::B_IDLE:
            begin
                if (req_valid && list_sts.ready)
                begin
                    req_next   = req;
                    axis_next  = '0;
                    state_next = clpb_pkg::B_LEN;
                end
            end
            clpb_pkg::B_LEN:
            begin
                len_next   = len_prod;
                state_next = clpb_pkg::B_FOLD;
            end
            clpb_pkg::B_FOLD:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.init_rem = '0;
                div_cmd.shift_in = pos_abs;
                div_cmd.steps    = clpb_pkg::STEP_W'(clpb_pkg::SH_W);
                div_cmd.divisor  = wrap_mode_reg ? len_ext : two_len;
                state_next       = clpb_pkg::B_FOLD_WAIT;
            end
            clpb_pkg::B_FOLD_WAIT:
            begin
                if (div_res.done)
                begin
                    f_next     = fold_val[LW-1:0];
                    state_next = clpb_pkg::B_QUOT;
                end
            end
            clpb_pkg::B_QUOT:
            begin
                // Fold is below 2^13 cell widths, so 13 quotient bits remain.
                div_cmd.start    = 1'b1;
                div_cmd.init_rem = DW'(f_reg >> CW);
                div_cmd.shift_in = {f_reg[CW-1:0], {(clpb_pkg::SH_W-CW){1'b0}}};
                div_cmd.steps    = clpb_pkg::STEP_W'(CW);
                div_cmd.divisor  = DW'(w_eff);
                state_next       = clpb_pkg::B_QUOT_WAIT;
            end
            clpb_pkg::B_QUOT_WAIT:
            begin
                if (div_res.done)
                begin
                    gc_next[axis_reg]   = (quo > cnt_max) ? cnt_max : quo;
                    fold_next[axis_reg] = f_sat;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = clpb_pkg::B_IDX_A;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = clpb_pkg::B_LEN;
                    end
                end
            end
            clpb_pkg::B_IDX_A:
            begin
                t_next     = gc_reg[2] * cy_eff + gc_reg[1];
                state_next = clpb_pkg::B_IDX_B;
            end
            clpb_pkg::B_IDX_B:
            begin
                idx_next   = t_reg * cx_eff + gc_reg[0];
                state_next = clpb_pkg::B_LIST;
            end
            clpb_pkg::B_LIST:
            begin
                list_cmd.start    = 1'b1;
                list_cmd.agent    = req_reg.agent_id;
                list_cmd.cell_idx = in_grid ? idx_reg[clpb_pkg::CELL_W-1:0]
                                            : clpb_pkg::NO_CELL;
                state_next        = clpb_pkg::B_LIST_WAIT;
            end
            clpb_pkg::B_LIST_WAIT:
            begin
                if (list_sts.done)
                begin
                    moved_next = list_sts.moved;
                    state_next = clpb_pkg::B_DONE;
                end
            end
            clpb_pkg::B_DONE:
            begin
                if (!rsp_valid_reg)
                begin
                    rsp_next.folded_x   = fold_reg[0];
                    rsp_next.folded_y   = fold_reg[1];
                    rsp_next.folded_z   = fold_reg[2];
                    rsp_next.cell_index = in_grid ? idx_reg[clpb_pkg::OUT_IDX_W-1:0] : '0;
                    rsp_next.moved      = moved_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = clpb_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = clpb_pkg::B_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == clpb_pkg::B_IDLE) && list_sts.ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    clpb_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .res   (div_res)
    );

    clpb_list u_list (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (list_cmd),
        .sts   (list_sts)
    );

endmodule

[rtl/clpb_checker.sv]
// Port-level checker for the cell list position binner, bound to the top.
// Depends on clpb_pkg for the response type.
module clpb_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input clpb_pkg::rsp_t rsp
);

    // A stalled response holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // One request in work at a time.
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // A taken response is never followed at once by another one.
    a_rsp_gap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("back-to-back response");

endmodule

bind cell_list_position_binner_unit clpb_checker u_clpb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[bench/testbench.sv]
// Self-checking bench for cell_list_position_binner_unit: random and directed
// agent position updates under several grid settings, checked against a model.
// Depends on rtl/clpb_pkg.sv and rtl/cell_list_position_binner_unit.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [clpb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam longint FOLD_MAX = 64'd2147483647;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int LONG_HOLD_CYCLES = 600;

    // Predicts the binner: grid settings, list memories and pending responses.
    class bin_scoreboard;
        clpb_pkg::rsp_t expected_q[$];
        int errors;
        int relinks;
        int requests;
        bit wrap_mode;
        longint cell_width;
        longint cells_x, cells_y, cells_z;
        int cell_head[clpb_pkg::MAX_CELLS];
        int agent_prev[clpb_pkg::MAX_AGENTS];
        int agent_next[clpb_pkg::MAX_AGENTS];
        int agent_cell[clpb_pkg::MAX_AGENTS];

        function new();
            wrap_mode = 1'b0;
            cell_width = 65536;
            cells_x = 16;
            cells_y = 16;
            cells_z = 16;
            foreach (cell_head[i]) cell_head[i] = clpb_pkg::NIL_AGENT;
            foreach (agent_cell[i])
            begin
                agent_cell[i] = clpb_pkg::NO_CELL;
                agent_prev[i] = 0;
                agent_next[i] = 0;
            end
        endfunction

        function void write_reg(logic [clpb_pkg::CFG_IDX_W-1:0] idx,
                                logic [clpb_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                clpb_pkg::CFG_WRAP_MODE:  wrap_mode = data[0];
                clpb_pkg::CFG_CELL_WIDTH: cell_width = data[30:0];
                clpb_pkg::CFG_CELLS_X:    cells_x = data[12:0];
                clpb_pkg::CFG_CELLS_Y:    cells_y = data[12:0];
                clpb_pkg::CFG_CELLS_Z:    cells_z = data[12:0];
                default: ;
            endcase
        endfunction

        // Fold one coordinate into a box of length len.
        function longint fold_pos(longint p, longint len);
            longint twice;
            longint r;
            twice = 2 * len;
            if (wrap_mode)
            begin
                r = p % len;
                if (r < 0) r += len;
                return r;
            end
            if (p < 0)
            begin
                r = p % twice;
                return (r > -len) ? -r : r + twice;
            end
            if (p >= len)
            begin
                r = p % twice;
                return (r >= len) ? twice - r : r;
            end
            return p;
        endfunction

        // Fold one axis; returns the cell coordinate and the saturated folded value.
        function longint bin_axis(longint p, longint count,
                                  output logic [clpb_pkg::FOLD_W-1:0] folded);
            longint cnt;
            longint w;
            longint f;
            longint c;
            cnt = (count != 0) ? count : 1;
            w = (cell_width != 0) ? cell_width : 1;
            f = fold_pos(p, cnt * w);
            c = f / w;
            if (c > cnt - 1) c = cnt - 1;
            folded = (f > FOLD_MAX) ? FOLD_MAX[clpb_pkg::FOLD_W-1:0]
                                    : f[clpb_pkg::FOLD_W-1:0];
            return c;
        endfunction

        function void note_request(clpb_pkg::req_t r);
            clpb_pkg::rsp_t e;
            longint gx, gy, gz, cx, cy, idx;
            int id, old_cell, new_cell, p, n, f;
            gx = bin_axis(longint'(r.pos_x), cells_x, e.folded_x);
            gy = bin_axis(longint'(r.pos_y), cells_y, e.folded_y);
            gz = bin_axis(longint'(r.pos_z), cells_z, e.folded_z);
            cx = (cells_x != 0) ? cells_x : 1;
            cy = (cells_y != 0) ? cells_y : 1;
            idx = (gz * cy + gy) * cx + gx;
            new_cell = (idx < clpb_pkg::MAX_CELLS) ? int'(idx) : int'(clpb_pkg::NO_CELL);
            id = r.agent_id;
            e.moved = 1'b0;
            old_cell = agent_cell[id];
            if (old_cell != new_cell)
            begin
                // Unlink from the old cell list.
                if (old_cell < clpb_pkg::NO_CELL)
                begin
                    p = agent_prev[id];
                    n = agent_next[id];
                    if (p < clpb_pkg::NIL_AGENT) agent_next[p] = n;
                    else cell_head[old_cell] = n;
                    if (n < clpb_pkg::NIL_AGENT) agent_prev[n] = p;
                end
                // Push at the head of the new cell list.
                if (new_cell < clpb_pkg::NO_CELL)
                begin
                    f = cell_head[new_cell];
                    if (f < clpb_pkg::NIL_AGENT) agent_prev[f] = id;
                    agent_next[id] = f;
                    agent_prev[id] = clpb_pkg::NIL_AGENT;
                    cell_head[new_cell] = id;
                end
                agent_cell[id] = new_cell;
                e.moved = 1'b1;
                relinks++;
            end
            e.cell_index = (idx < clpb_pkg::MAX_CELLS) ? idx[clpb_pkg::OUT_IDX_W-1:0] : '0;
            expected_q.push_back(e);
            requests++;
        endfunction

        function void check_response(clpb_pkg::rsp_t a);
            clpb_pkg::rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("response with no request pending: %p", a);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.folded_x !== e.folded_x)
            begin
                $error("folded_x expected %0d actual %0d", e.folded_x, a.folded_x);
                errors++;
            end
            if (a.folded_y !== e.folded_y)
            begin
                $error("folded_y expected %0d actual %0d", e.folded_y, a.folded_y);
                errors++;
            end
            if (a.folded_z !== e.folded_z)
            begin
                $error("folded_z expected %0d actual %0d", e.folded_z, a.folded_z);
                errors++;
            end
            if (a.cell_index !== e.cell_index)
            begin
                $error("cell_index expected %0d actual %0d", e.cell_index, a.cell_index);
                errors++;
            end
            if (a.moved !== e.moved)
            begin
                $error("moved expected %0d actual %0d", e.moved, a.moved);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    clpb_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    clpb_pkg::rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [clpb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [clpb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bin_scoreboard sb = new();
    bit quiet = 1'b0;
    bit long_hold = 1'b0;
    int settings_used = 0;

    cell_list_position_binner_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Note accepted requests and check accepted responses.
    always @(posedge clk)
    begin
        if (req_valid && req_ready) sb.note_request(req);
        if (rsp_valid && rsp_ready) sb.check_response(rsp);
    end

    // Response side: random stall bursts, and one long hold-off on demand.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                rsp_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted, with an optional gap first.
    task automatic send_request(logic [clpb_pkg::AGENT_W-1:0] id, longint px, longint py,
                                longint pz);
        clpb_pkg::req_t r;
        r.agent_id = id;
        r.pos_x = px[31:0];
        r.pos_y = py[31:0];
        r.pos_z = pz[31:0];
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
    endtask

    // Wait until every response is in, then let the block settle.
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [clpb_pkg::CFG_IDX_W-1:0] idx,
                             logic [clpb_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(bit wrap, longint w, int cx, int cy, int cz);
        drain();
        write_reg(clpb_pkg::CFG_WRAP_MODE, 32'(wrap));
        write_reg(clpb_pkg::CFG_CELL_WIDTH, w[31:0]);
        write_reg(clpb_pkg::CFG_CELLS_X, cx);
        write_reg(clpb_pkg::CFG_CELLS_Y, cy);
        write_reg(clpb_pkg::CFG_CELLS_Z, cz);
        settings_used++;
    endtask

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Pick a coordinate: mostly near the box, sometimes on a wall, sometimes anything.
    function automatic longint pick_pos(longint count);
        longint len;
        longint span;
        int mode;
        len = ((count != 0) ? count : 1) * ((sb.cell_width != 0) ? sb.cell_width : 1);
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            span = 5 * len;
            if (span > 64'd4294967295) span = 64'd4294967295;
            return clamp32(longint'({$urandom, $urandom} % span) - 2 * len);
        end
        if (mode < 8)
            return clamp32(longint'($urandom_range(0, 4)) * len - 2 * len
                           + longint'($urandom_range(0, 2)) - 1);
        return longint'($signed($urandom));
    endfunction

    function automatic logic [clpb_pkg::AGENT_W-1:0] pick_agent();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 7) return clpb_pkg::AGENT_W'($urandom_range(0, 15));
        if (mode < 9) return clpb_pkg::AGENT_W'($urandom_range(0, 63));
        return clpb_pkg::AGENT_W'($urandom_range(0, clpb_pkg::MAX_AGENTS - 1));
    endfunction

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++)
        begin
            send_request(pick_agent(), pick_pos(sb.cells_x), pick_pos(sb.cells_y),
                         pick_pos(sb.cells_z));
        end
    endtask

    // Main stimulus.
    initial
    begin
        longint unit_len;
        unit_len = 16 * 65536;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: default grid in reflect mode, walls, extremes, list shuffles.
        send_request(0, 0, 0, 0);
        send_request(1, 0, 0, 0);
        send_request(2, 0, 0, 0);
        send_request(1, 0, 0, 0);
        send_request(1, 65536, 0, 0);
        send_request(2, unit_len, unit_len, unit_len);
        send_request(0, unit_len - 1, -1, 2 * unit_len);
        send_request(1023, 64'sd2147483647, -64'sd2147483648, -unit_len);
        send_request(1023, 3 * unit_len, -3 * unit_len + 1, 5);

        // Directed: wrap mode, exact multiples of the box fold to zero.
        set_grid(1'b1, 65536, 16, 16, 16);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_request(3, unit_len, -unit_len, 2 * unit_len);
        send_request(3, -1, unit_len - 1, -64'sd2147483648);
        send_request(4, 64'sd2147483647, 0, -unit_len - 1);
        send_request(0, 0, 0, 0);

        // Directed: a box wider than the output field saturates the folded value.
        set_grid(1'b0, 64'd2147483647, 4096, 4096, 4096);
        send_request(5, -64'sd2147483648, 64'sd2147483647, -1);
        send_request(5, 0, 0, 0);
        // Zero sizes act as one.
        set_grid(1'b0, 0, 0, 0, 0);
        send_request(6, 1, -1, 64'sd2147483647);
        send_request(6, -64'sd2147483648, 0, 2);

        // Random phases across grid settings.
        set_grid(1'b0, 1, 4096, 1, 1);
        random_phase(ITEMS_PER_PHASE / 2);
        drain();
        random_phase(ITEMS_PER_PHASE / 2);

        set_grid(1'b1, 64'd2147483647, 4096, 4096, 4096);
        random_phase(ITEMS_PER_PHASE);

        set_grid(1'b0, 3 << 15, 4, 3, 2);
        random_phase(ITEMS_PER_PHASE / 2);
        long_hold = 1'b1;
        random_phase(ITEMS_PER_PHASE / 2);

        set_grid(1'b1, 1 << 16, 8191, 2, 1);
        random_phase(ITEMS_PER_PHASE);

        set_grid(1'b0, 64'd2147483647, 1, 1, 1);
        random_phase(ITEMS_PER_PHASE / 2);

        set_grid(1'b0, 0, 8191, 8191, 8191);
        random_phase(ITEMS_PER_PHASE / 2);

        for (int ph = 0; ph < 2; ph++)
        begin
            set_grid(1'($urandom_range(0, 1)), $urandom_range(1, 1 << 20),
                     $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20));
            random_phase(ITEMS_PER_PHASE);
        end

        // Final stretch with no idling on either side.
        set_grid(1'b1, 1 << 15, 8, 8, 8);
        quiet = 1'b1;
        random_phase(ITEMS_PER_PHASE);

        drain();
        $display("Covered %0d requests over %0d grid settings, %0d of them relinking.",
                 sb.requests, settings_used, sb.relinks);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

[cell_list_position_binner_unit.f]
rtl/clpb_pkg.sv
rtl/clpb_divider.sv
rtl/clpb_list.sv
rtl/cell_list_position_binner_unit.sv
rtl/clpb_checker.sv
bench/testbench.sv
